[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the path search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

[hdl/gasp_pkg.sv]
// ----------------------------------------------------------------------------
// gasp_pkg
// Types and constants shared by the grid path search cells and top level.
// ----------------------------------------------------------------------------
package gasp_pkg;
    localparam int COST_W = 40;
    localparam int REG_W  = 34;
    localparam int NREGS  = 8;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [2:0] REG_IDX_MAX = 3'd7;

    typedef enum logic {FUNC_WRITE = 1'b0, FUNC_SEARCH = 1'b1} func_t;

    // Per-cell data handed down the chain during a minimum scan.
    typedef struct packed {
        logic              found;
        logic [COST_W:0]   f;
        logic [5:0]        idx;
    } scan_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              clear;     // start of search: clear marks
        logic              seed;      // mark start cell open with g = 0
        logic [5:0]        seed_idx;  // also the cell of a terrain write
        logic              terr_we;   // write terrain class of seed_idx
        logic [1:0]        terr_cls;
        logic              close;     // close the selected cell
        logic [5:0]        close_idx;
        logic              relax;     // relax one neighbour
        logic [5:0]        relax_idx;
        logic [COST_W-1:0] relax_g;
        logic [2:0]        relax_dir;
        logic              scan_load; // latch f into scan chain
        logic [2:0]        gx;
        logic [2:0]        gy;
    } cell_ctl_t;

    function automatic logic signed [4:0] step_dx(input logic [2:0] d);
        unique case (d)
            3'd0, 3'd4, 3'd6: step_dx = -5'sd1;
            3'd1, 3'd5, 3'd7: step_dx = 5'sd1;
            default:          step_dx = 5'sd0;
        endcase
    endfunction

    function automatic logic signed [4:0] step_dy(input logic [2:0] d);
        unique case (d)
            3'd2, 3'd4, 3'd7: step_dy = -5'sd1;
            3'd3, 3'd5, 3'd6: step_dy = 5'sd1;
            default:          step_dy = 5'sd0;
        endcase
    endfunction
endpackage

[hdl/grid_astar_path_search_unit.sv]
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// A* path search over an 8-neighbour grid built as a chain of cells.
// ----------------------------------------------------------------------------
// One word with func 0 writes a cell's terrain class and returns nothing. A
// word with func 1 searches from (cell_x,cell_y) to (goal_x,goal_y) and
// returns the path goal first, one word per cell, each with the total cost,
// tlast on the start cell. Each expansion shifts the minimum-f candidate down
// the cell chain, then relaxes eight neighbours one per cycle. Input is not
// taken during a search.
`include "assert_macros.svh"
module grid_astar_path_search_unit import gasp_pkg::*; #(
    parameter int GRID_W = 8,
    parameter int GRID_H = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // func[0], cell_x[3:1], cell_y[6:4], terrain_class[8:7], goal_x[11:9],
    // goal_y[14:12], zero fill [15]
    input  logic [15:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // path_x[2:0], path_y[5:3], path_cost[45:6], zero fill [47:46]
    output logic [47:0]      m_tdata,
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_wdata
);
    localparam int NC = GRID_W * GRID_H;
    localparam int CW = $clog2(NC + 2);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_PICK, ST_RELAX, ST_EMIT
    } state_t;

    logic [REG_W-1:0] regs_reg [NREGS];
    state_t           state_reg;
    logic [CW-1:0]    cnt_reg;
    logic [2:0]       sx_reg, sy_reg, gx_reg, gy_reg, cx_reg, cy_reg, d_reg;
    logic [COST_W-1:0] gcur_reg, total_reg;
    logic             ov_reg;
    logic [47:0]      out_data_reg;
    logic             out_last_reg;

    cell_ctl_t        ctl;
    scan_t            chain [NC+1];
    logic [COST_W-1:0] g_arr [NC];
    logic [2:0]        dir_arr [NC];
    logic [1:0]        terr_arr [NC];
    logic [NC-1:0]     open_v, closed_v;

    logic        in_func;
    logic [2:0]  in_x, in_y, in_gx, in_gy;
    logic [1:0]  in_cls;
    assign in_func = s_tdata[0];
    assign in_x  = s_tdata[3:1];
    assign in_y  = s_tdata[6:4];
    assign in_cls = s_tdata[8:7];
    assign in_gx = s_tdata[11:9];
    assign in_gy = s_tdata[14:12];

    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;

    assign chain[0] = '0;
    for (genvar i = 0; i < NC; i++) begin : g_cells
        gasp_cell #(
            .IDX(6'(i)), .CX(3'(i % GRID_W)), .CY(3'(i / GRID_W))
        ) u_cell (
            .aclk, .aresetn, .ctl,
            .scan_in(chain[i]), .scan_out(chain[i+1]),
            .g_out(g_arr[i]), .dir_out(dir_arr[i]), .terr_out(terr_arr[i]),
            .open_out(open_v[i]), .closed_out(closed_v[i])
        );
    end

    function automatic logic [5:0] cidx(input logic [2:0] x, input logic [2:0] y);
        cidx = 6'(int'(y) * GRID_W + int'(x));
    endfunction

    // Column and row of a cell index: constant lookup over the grid.
    function automatic logic [2:0] col_of(input logic [5:0] idx);
        col_of = '0;
        for (int i = 0; i < NC; i++)
            if (idx == 6'(i)) col_of = 3'(i % GRID_W);
    endfunction

    function automatic logic [2:0] row_of(input logic [5:0] idx);
        row_of = '0;
        for (int i = 0; i < NC; i++)
            if (idx == 6'(i)) row_of = 3'(i / GRID_W);
    endfunction

    // Neighbour of the expanded cell in direction d_reg.
    logic signed [4:0] nx, ny;
    logic              n_ok;
    logic [5:0]        n_idx;
    logic [REG_W-1:0]  step;
    logic [COST_W:0]   gsum;
    always_comb begin
        nx = $signed({2'b0, cx_reg}) + step_dx(d_reg);
        ny = $signed({2'b0, cy_reg}) + step_dy(d_reg);
        n_ok = (nx >= 0) && (nx < GRID_W) && (ny >= 0) && (ny < GRID_H);
        n_idx = cidx(nx[2:0], ny[2:0]);
        step = regs_reg[{d_reg[2], terr_arr[n_idx[$clog2(NC)-1:0]]}];
        gsum = {1'b0, gcur_reg} + {{(COST_W+1-REG_W){1'b0}}, step};
    end

    logic [5:0] best;
    logic [2:0] best_x, best_y;
    assign best = chain[NC].idx;
    assign best_x = col_of(best);
    assign best_y = row_of(best);

    always_comb begin
        ctl = '0;
        ctl.gx = gx_reg; ctl.gy = gy_reg;
        ctl.scan_load = (state_reg == ST_SCAN);
        ctl.seed_idx = cidx(in_x, in_y);
        ctl.terr_cls = in_cls;
        if (state_reg == ST_IDLE && s_tvalid && s_tready && in_func == FUNC_SEARCH) begin
            ctl.clear = 1'b1; ctl.seed = 1'b1;
        end
        // Writes outside the grid are dropped.
        ctl.terr_we = (state_reg == ST_IDLE) && s_tvalid && s_tready &&
                      in_func == FUNC_WRITE && in_x < GRID_W && in_y < GRID_H;
        ctl.close = (state_reg == ST_PICK) && chain[NC].found;
        ctl.close_idx = best;
        ctl.relax = (state_reg == ST_RELAX) && n_ok;
        ctl.relax_idx = n_idx;
        ctl.relax_g = gsum[COST_W] ? COST_MAX : gsum[COST_W-1:0];
        ctl.relax_dir = d_reg;
    end

    logic out_fire, emit_load;
    assign out_fire = ov_reg && m_tready;
    assign emit_load = (state_reg == ST_EMIT) && (!ov_reg || m_tready);
    logic [2:0] px, py;
    logic [5:0] pidx;
    always_comb begin
        pidx = cidx(cx_reg, cy_reg);
        px = 3'(signed'({2'b0, cx_reg}) - step_dx(dir_arr[pidx[$clog2(NC)-1:0]]));
        py = 3'(signed'({2'b0, cy_reg}) - step_dy(dir_arr[pidx[$clog2(NC)-1:0]]));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
            sx_reg <= in_x; sy_reg <= in_y; gx_reg <= in_gx; gy_reg <= in_gy;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE; ov_reg <= 1'b0; cnt_reg <= '0; d_reg <= '0;
            regs_reg[0] <= REG_W'(10);  regs_reg[1] <= REG_W'(15);
            regs_reg[2] <= REG_W'(20);  regs_reg[3] <= REG_W'(64'd10000000000);
            regs_reg[4] <= REG_W'(14);  regs_reg[5] <= REG_W'(21);
            regs_reg[6] <= REG_W'(28);  regs_reg[7] <= REG_W'(64'd14142135623);
        end else begin
            if (cfg_we && cfg_index <= REG_IDX_MAX) regs_reg[cfg_index] <= cfg_wdata;
            // Output register: reload wins over drain in the same cycle.
            if (emit_load) ov_reg <= 1'b1;
            else if (out_fire) ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready && in_func == FUNC_SEARCH &&
                             in_x < GRID_W && in_y < GRID_H &&
                             in_gx < GRID_W && in_gy < GRID_H) begin
                    state_reg <= ST_SCAN; cnt_reg <= '0;
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NC)) state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    if (!chain[NC].found) state_reg <= ST_IDLE;
                    else begin
                        cx_reg <= best_x; cy_reg <= best_y;
                        gcur_reg <= g_arr[best[$clog2(NC)-1:0]];
                        d_reg <= '0;
                        if (best_x == gx_reg && best_y == gy_reg) begin
                            total_reg <= g_arr[best[$clog2(NC)-1:0]];
                            state_reg <= ST_EMIT;
                        end else state_reg <= ST_RELAX;
                    end
                end
                ST_RELAX: begin
                    d_reg <= d_reg + 1'b1;
                    if (d_reg == 3'd7) begin state_reg <= ST_SCAN; cnt_reg <= '0; end
                end
                ST_EMIT: if (emit_load) begin
                    out_data_reg <= {2'b0, total_reg, cy_reg, cx_reg};
                    out_last_reg <= (cx_reg == sx_reg && cy_reg == sy_reg);
                    if (cx_reg == sx_reg && cy_reg == sy_reg) state_reg <= ST_IDLE;
                    else begin cx_reg <= px; cy_reg <= py; end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_NEVER(a_open_closed, aclk, aresetn, |(open_v & closed_v), "cell open and closed")
    `ASSERT_IMPL(a_no_take_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_tready, "busy take")
    `ASSERT_IMPL(a_scan_len, aclk, aresetn, (state_reg == ST_PICK) |-> $past(state_reg == ST_SCAN), "pick w/o scan")
endmodule

[hdl/gasp_cell.sv]
// ----------------------------------------------------------------------------
// gasp_cell
// One grid cell: holds terrain class, g, parent, open/closed marks and runs one
// stage of the minimum-f scan shift chain.
// ----------------------------------------------------------------------------
module gasp_cell import gasp_pkg::*; #(
    parameter logic [5:0] IDX = 6'd0,
    parameter logic [2:0] CX  = 3'd0,
    parameter logic [2:0] CY  = 3'd0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctl_t         ctl,
    input  scan_t             scan_in,
    output scan_t             scan_out,
    output logic [COST_W-1:0] g_out,
    output logic [2:0]        dir_out,
    output logic [1:0]        terr_out,
    output logic              open_out,
    output logic              closed_out
);
    logic [COST_W-1:0] g_reg, g_next;
    logic [2:0]        dir_reg, dir_next;
    logic [1:0]        terr_reg, terr_next;
    logic              open_reg, open_next, closed_reg, closed_next;
    scan_t             hold_reg, hold_next;
    logic [3:0]        ax, ay;
    logic [7:0]        h_here;
    logic [COST_W:0]   f_here;
    logic              take;

    always_comb begin
        ax = (CX > ctl.gx) ? {1'b0, CX - ctl.gx} : {1'b0, ctl.gx - CX};
        ay = (CY > ctl.gy) ? {1'b0, CY - ctl.gy} : {1'b0, ctl.gy - CY};
        h_here = ({4'b0, ax} + {4'b0, ay}) * 8'd10;
        f_here = {1'b0, g_reg} + {{(COST_W-7){1'b0}}, h_here};
    end

    // Shift stage: take own candidate only when strictly better, so ties keep
    // the lower cell index coming down the chain.
    always_comb begin
        take = open_reg && (!scan_in.found || f_here < scan_in.f);
        hold_next = hold_reg;
        if (ctl.scan_load) begin
            hold_next.found = take || scan_in.found;
            hold_next.f     = take ? f_here : scan_in.f;
            hold_next.idx   = take ? IDX : scan_in.idx;
        end
    end

    always_comb begin
        g_next = g_reg; dir_next = dir_reg; terr_next = terr_reg;
        open_next = open_reg; closed_next = closed_reg;
        if (ctl.terr_we && ctl.seed_idx == IDX) begin
            terr_next = ctl.terr_cls;
        end
        if (ctl.clear) begin
            open_next = 1'b0; closed_next = 1'b0;
        end
        if (ctl.seed && ctl.seed_idx == IDX) begin
            open_next = 1'b1; g_next = '0;
        end
        if (ctl.close && ctl.close_idx == IDX) begin
            open_next = 1'b0; closed_next = 1'b1;
        end
        if (ctl.relax && ctl.relax_idx == IDX && !closed_reg &&
            (!open_reg || ctl.relax_g < g_reg)) begin
            g_next = ctl.relax_g; dir_next = ctl.relax_dir; open_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg    <= g_next;
        dir_reg  <= dir_next;
        hold_reg <= hold_next;
        if (!aresetn) begin
            open_reg <= 1'b0; closed_reg <= 1'b0; terr_reg <= 2'd0;
        end else begin
            open_reg <= open_next; closed_reg <= closed_next; terr_reg <= terr_next;
        end
    end

    assign scan_out   = hold_reg;
    assign g_out      = g_reg;
    assign dir_out    = dir_reg;
    assign terr_out   = terr_reg;
    assign open_out   = open_reg;
    assign closed_out = closed_reg;
endmodule

[verif/grid_astar_path_search_checker.sv]
// ----------------------------------------------------------------------------
// grid_astar_path_search_checker
// Watches both streams and the register port, models the grid search and
// compares every path word with the predicted path.
// ----------------------------------------------------------------------------
module grid_astar_path_search_checker import gasp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [47:0]      m_tdata,
    input  logic             m_tlast,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               words_seen,
    output int               searches_seen
);
    typedef struct packed {
        logic [2:0]        x;
        logic [2:0]        y;
        logic [COST_W-1:0] cost;
        logic              last;
    } path_word_t;

    logic [REG_W-1:0]  step_cost [NREGS];
    logic [1:0]        terrain   [64];
    logic [COST_W-1:0] g_cost    [64];
    logic [2:0]        came_dir  [64];
    logic              is_open   [64];
    logic              is_closed [64];
    path_word_t        path_q [$];

    assign pending = path_q.size();

    function automatic int dx_of(input int d);
        case (d)
            0, 4, 6: return -1;
            1, 5, 7: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int dy_of(input int d);
        case (d)
            2, 4, 7: return -1;
            3, 5, 6: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [COST_W:0] dist_cost(input int x, y, gx, gy);
        int ax, ay;
        ax = x > gx ? x - gx : gx - x;
        ay = y > gy ? y - gy : gy - y;
        return (COST_W+1)'((ax + ay) * 10);
    endfunction

    // Search from (sx,sy) to (gx,gy); queue path words goal first.
    task automatic plan_path(input int sx, sy, gx, gy);
        int best, cx, cy, nx, ny, ni, n;
        logic [COST_W:0] f, best_f, g;
        logic [COST_W-1:0] total;
        for (int i = 0; i < 64; i++) begin
            is_open[i] = 1'b0;
            is_closed[i] = 1'b0;
        end
        g_cost[sy*8+sx] = '0;
        is_open[sy*8+sx] = 1'b1;
        for (int it = 0; it < 64; it++) begin
            best = -1;
            best_f = '0;
            for (int i = 0; i < 64; i++) begin
                if (is_open[i]) begin
                    f = {1'b0, g_cost[i]} + dist_cost(i % 8, i / 8, gx, gy);
                    if (best < 0 || f < best_f) begin
                        best = i;
                        best_f = f;
                    end
                end
            end
            if (best < 0) return;
            is_open[best] = 1'b0;
            is_closed[best] = 1'b1;
            cx = best % 8;
            cy = best / 8;
            if (cx == gx && cy == gy) begin
                total = g_cost[best];
                n = 0;
                while (n < 64) begin
                    path_q.insert(path_q.size(), '{x: cx[2:0], y: cy[2:0], cost: total,
                                                   last: (cx == sx && cy == sy)});
                    n++;
                    if (cx == sx && cy == sy) break;
                    ni = int'(came_dir[cy*8+cx]);
                    cx -= dx_of(ni);
                    cy -= dy_of(ni);
                    if (cx < 0 || cx > 7 || cy < 0 || cy > 7) break;
                end
                return;
            end
            for (int d = 0; d < 8; d++) begin
                nx = cx + dx_of(d);
                ny = cy + dy_of(d);
                if (nx < 0 || nx > 7 || ny < 0 || ny > 7) continue;
                ni = ny*8 + nx;
                if (is_closed[ni]) continue;
                g = {1'b0, g_cost[best]} +
                    {{(COST_W+1-REG_W){1'b0}}, step_cost[(d < 4 ? 0 : 4) + terrain[ni]]};
                if (g > {1'b0, COST_MAX}) g = {1'b0, COST_MAX};
                if (is_open[ni] && g[COST_W-1:0] >= g_cost[ni]) continue;
                g_cost[ni] = g[COST_W-1:0];
                came_dir[ni] = d[2:0];
                is_open[ni] = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        path_word_t exp_w;
        if (!aresetn) begin
            step_cost[0] <= REG_W'(10);
            step_cost[1] <= REG_W'(15);
            step_cost[2] <= REG_W'(20);
            step_cost[3] <= 34'd10000000000;
            step_cost[4] <= REG_W'(14);
            step_cost[5] <= REG_W'(21);
            step_cost[6] <= REG_W'(28);
            step_cost[7] <= 34'd14142135623;
            for (int i = 0; i < 64; i++) terrain[i] <= 2'd0;
            fail_count <= 0;
            words_seen <= 0;
            searches_seen <= 0;
            path_q.delete();
        end else begin
            if (cfg_we) step_cost[cfg_index] <= cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (func_t'(s_tdata[0]) == FUNC_WRITE) begin
                    terrain[s_tdata[6:4]*8 + s_tdata[3:1]] <= s_tdata[8:7];
                end else begin
                    plan_path(s_tdata[3:1], s_tdata[6:4], s_tdata[11:9], s_tdata[14:12]);
                    searches_seen <= searches_seen + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                words_seen <= words_seen + 1;
                if (path_q.size() == 0) begin
                    $error("path word with none expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = path_q.pop_front();
                    if (m_tdata[2:0] != exp_w.x) begin
                        $error("path_x expected %0d got %0d", exp_w.x, m_tdata[2:0]);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tdata[5:3] != exp_w.y) begin
                        $error("path_y expected %0d got %0d", exp_w.y, m_tdata[5:3]);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tdata[45:6] != exp_w.cost) begin
                        $error("path_cost expected %0d got %0d", exp_w.cost, m_tdata[45:6]);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tlast != exp_w.last) begin
                        $error("last expected %0d got %0d", exp_w.last, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/grid_astar_path_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit_tb
// Drives terrain writes and searches with random gaps on both streams, walks
// the step cost registers through several settings and takes the verdict
// from the checker.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit_tb;
    import gasp_pkg::*;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [47:0]      m_tdata;
    logic             m_tlast;
    logic             cfg_we = 0;
    logic [2:0]       cfg_index = '0;
    logic [REG_W-1:0] cfg_wdata = '0;
    int               fail_count, pending, words_seen, searches_seen;

    localparam logic [REG_W-1:0] REG_FULL = {REG_W{1'b1}};

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    grid_astar_path_search_unit DUT (.*);
    grid_astar_path_search_checker u_chk (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls: random gaps, then one ready cycle.
    always begin
        int n;
        n = gap_len();
        if (n > 0) begin
            m_tready <= 0;
            repeat (n) @(posedge aclk);
        end
        m_tready <= 1;
        @(posedge aclk);
    end

    // One word on the input stream; tvalid stays high until the handshake.
    task automatic send_word(input func_t fn, input logic [2:0] x, y,
                             input logic [1:0] cls, input logic [2:0] gx, gy);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tdata  <= {1'b0, gy, gx, cls, y, x, fn};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_cost(input int idx, input logic [REG_W-1:0] val);
        cfg_index <= idx[2:0];
        cfg_wdata <= val;
        cfg_we    <= 1;
        @(posedge aclk);
        cfg_we    <= 0;
        @(posedge aclk);
    endtask

    // Let the last search finish and its path words drain before touching
    // the registers.
    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0 || !s_tready) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55)
                send_word(FUNC_WRITE, 3'($urandom), 3'($urandom), 2'($urandom),
                          3'($urandom), 3'($urandom));
            else
                send_word(FUNC_SEARCH, 3'($urandom), 3'($urandom), 2'($urandom),
                          3'($urandom), 3'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: default costs, start equals goal, corner to corner.
        send_word(FUNC_SEARCH, 3'd2, 3'd5, 2'd0, 3'd2, 3'd5);
        send_word(FUNC_SEARCH, 3'd0, 3'd0, 2'd3, 3'd7, 3'd7);
        send_word(FUNC_SEARCH, 3'd7, 3'd7, 2'd0, 3'd0, 3'd0);
        send_word(FUNC_SEARCH, 3'd7, 3'd0, 2'd0, 3'd0, 3'd7);
        // A wall across the middle whose cells cycle through each class.
        for (int y = 0; y < 8; y++)
            send_word(FUNC_WRITE, 3'd4, y[2:0], y[1:0], 3'd0, 3'd0);
        send_word(FUNC_WRITE, 3'd3, 3'd3, 2'd3, 3'd7, 3'd7);
        send_word(FUNC_SEARCH, 3'd0, 3'd3, 2'd0, 3'd7, 3'd3);
        send_word(FUNC_SEARCH, 3'd7, 3'd1, 2'd0, 3'd0, 3'd6);
        wait_idle();

        // Extremes of the registers: all zero, then all ones.
        for (int r = 0; r < NREGS; r++) write_cost(r, '0);
        send_word(FUNC_SEARCH, 3'd0, 3'd0, 2'd0, 3'd7, 3'd6);
        wait_idle();
        for (int r = 0; r < NREGS; r++) write_cost(r, REG_FULL);
        send_word(FUNC_SEARCH, 3'd0, 3'd0, 2'd0, 3'd7, 3'd7);
        send_word(FUNC_SEARCH, 3'd6, 3'd1, 2'd0, 3'd1, 3'd4);
        wait_idle();

        // Random phases, each under fresh random costs.
        for (int ph = 0; ph < 4; ph++) begin
            for (int r = 0; r < NREGS; r++)
                write_cost(r, (ph % 2) ? REG_W'({$urandom, $urandom})
                                       : REG_W'($urandom_range(0, 40)));
            random_items(25);
            wait_idle();
        end

        repeat (200) @(posedge aclk);
        $display("Ran %0d searches, checked %0d path words, costs at zero, full and random.",
                 searches_seen, words_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
